[sv/bcast_pkg.sv]
// Package for the broadcast operand index generator: defaults, reset values and register codes.
`default_nettype none
package bcast_pkg;

  localparam int unsigned MaxRankDef   = 4;
  localparam int unsigned DimBitsDef   = 16;
  localparam int unsigned IndexBitsDef = 32;

  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 64;
  localparam int unsigned RankBits    = 3;

  localparam logic [CfgDataBits-1:0] ShapeReset = 64'h0001_0001_0001_0001;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_RESULT_SHAPE  = 2'd0,
    REG_OPERAND_SHAPE = 2'd1,
    REG_RESULT_RANK   = 2'd2,
    REG_OPERAND_RANK  = 2'd3
  } cfg_reg_e;

endpackage
`default_nettype wire

[sv/broadcast_operand_index.sv]
// Throughput: one index per cycle; busy_o stays low, the receiver cannot stall.
// An input register, then per axis a restoring divider of INDEX_BITS one-bit stages,
// a multiply stage and an accumulate stage; the divider chain sets the latency.
// Reset: all shape dimensions 1, both ranks 0, pipeline emptied.
`default_nettype none
module broadcast_operand_index #(
  parameter int unsigned MAX_RANK   = bcast_pkg::MaxRankDef,
  parameter int unsigned DIM_BITS   = bcast_pkg::DimBitsDef,
  parameter int unsigned INDEX_BITS = bcast_pkg::IndexBitsDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire logic [31:0]                        output_index_i,
  output logic                                    result_valid_o,
  output logic [31:0]                             operand_index_o,
  output logic                                    shape_error_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [bcast_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  wire logic [bcast_pkg::CfgDataBits-1:0]  cfg_wdata_i
);
  import bcast_pkg::*;

  localparam int unsigned DB = DIM_BITS;
  localparam int unsigned IB = INDEX_BITS;
  localparam int unsigned Lat = 1 + MAX_RANK * (IB + 2);
  localparam logic [3:0] MaxR = 4'(MAX_RANK);

  typedef struct packed {
    logic          vld;
    logic          kill;
    logic          err;
    logic [DB-1:0] rem;
    logic [IB-1:0] num;
    logic [IB-1:0] acc;
    logic [IB-1:0] stride;
    logic [IB-1:0] prod;
  } ps_t;

  logic [CfgDataBits-1:0] res_shape_q, op_shape_q;
  logic [RankBits-1:0]    res_rank_q, op_rank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_shape_q <= ShapeReset;
      op_shape_q  <= ShapeReset;
      res_rank_q  <= '0;
      op_rank_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_RESULT_SHAPE:  res_shape_q <= cfg_wdata_i;
        REG_OPERAND_SHAPE: op_shape_q  <= cfg_wdata_i;
        REG_RESULT_RANK:   res_rank_q  <= cfg_wdata_i[RankBits-1:0];
        REG_OPERAND_RANK:  op_rank_q   <= cfg_wdata_i[RankBits-1:0];
        default: ;
      endcase
    end
  end

  // saturate ranks
  logic [3:0] rr_c, or_c;
  assign rr_c = ({1'b0, res_rank_q} > MaxR) ? MaxR : {1'b0, res_rank_q};
  assign or_c = ({1'b0, op_rank_q} > MaxR) ? MaxR : {1'b0, op_rank_q};

  logic [DB-1:0]       rd [MAX_RANK];
  logic [DB-1:0]       od [MAX_RANK];
  logic [MAX_RANK-1:0] act, use_op, dim_zero;

  for (genvar k = 0; k < MAX_RANK; k++) begin : g_dim
    // fields above bit 63 read as zero
    assign rd[k] = (k * DB < CfgDataBits) ? DB'(res_shape_q >> (k * DB)) : '0;
    assign od[k] = (k * DB < CfgDataBits) ? DB'(op_shape_q >> (k * DB)) : '0;
    assign act[k]      = 4'(k) < rr_c;
    assign use_op[k]   = 4'(k) < or_c;
    assign dim_zero[k] = act[k] && (rd[k] == '0);
  end

  logic err_c;
  assign err_c = (or_c != '0) && ((or_c > rr_c) || (|dim_zero));

  assign busy_o = 1'b0;

  ps_t ax_q [MAX_RANK+1];
  ps_t dv_q [MAX_RANK][IB];
  ps_t ms_q [MAX_RANK];

  ps_t ax_d;
  always_comb begin
    ax_d        = '0;
    ax_d.vld    = start_i && !busy_o;
    ax_d.err    = err_c;
    ax_d.kill   = (or_c == '0) || err_c;
    ax_d.num    = IB'(output_index_i);
    ax_d.stride = IB'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ax_q[0] <= '0;
    else         ax_q[0] <= ax_d;
  end

  for (genvar k = 0; k < MAX_RANK; k++) begin : g_axis
    for (genvar j = 0; j < IB; j++) begin : g_step
      ps_t           src, nxt;
      logic [DB:0]   trial;
      if (j == 0) begin : g_first
        // start each axis with an empty remainder
        always_comb begin
          src     = ax_q[k];
          src.rem = '0;
        end
      end else begin : g_next
        assign src = dv_q[k][j-1];
      end
      always_comb begin
        nxt   = src;
        trial = {src.rem, src.num[IB-1]};
        if (act[k]) begin
          nxt.num = {src.num[IB-2:0], 1'b0};
          if (trial >= {1'b0, rd[k]}) begin
            nxt.rem    = DB'(trial - {1'b0, rd[k]});
            nxt.num[0] = 1'b1;
          end else begin
            nxt.rem = trial[DB-1:0];
          end
        end
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) dv_q[k][j] <= '0;
        else         dv_q[k][j] <= nxt;
      end
    end

    ps_t                ms_d, ax_n;
    logic [IB+DB-1:0]   p_c, s_c;
    always_comb begin
      ms_d      = dv_q[k][IB-1];
      ms_d.prod = '0;
      p_c       = dv_q[k][IB-1].stride * dv_q[k][IB-1].rem;
      s_c       = dv_q[k][IB-1].stride * od[k];
      if (use_op[k]) begin
        if (od[k] != DB'(1)) ms_d.prod = p_c[IB-1:0];
        ms_d.stride = s_c[IB-1:0];
      end
    end
    always_comb begin
      ax_n      = ms_q[k];
      ax_n.acc  = ms_q[k].acc + ms_q[k].prod;
      ax_n.prod = '0;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ms_q[k]   <= '0;
        ax_q[k+1] <= '0;
      end else begin
        ms_q[k]   <= ms_d;
        ax_q[k+1] <= ax_n;
      end
    end
  end

  assign result_valid_o  = ax_q[MAX_RANK].vld;
  assign shape_error_o   = ax_q[MAX_RANK].err;
  assign operand_index_o = ax_q[MAX_RANK].kill ? 32'd0 : 32'(ax_q[MAX_RANK].acc);

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Lat result_valid_o)
    else $error("result strobe missing after pipeline latency");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && shape_error_o) |-> (operand_index_o == 32'd0))
    else $error("shape error with nonzero operand index");

  a_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ax_q[0].vld |=> dv_q[0][0].vld)
    else $error("transfer lost in first divider stage");

endmodule
`default_nettype wire

[tb/broadcast_index_checker.sv]
// Checker for the broadcast operand index generator: predicts and compares each result.
`timescale 1ns / 100ps
module broadcast_index_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        busy_i,
  input  wire logic [31:0] output_index_i,
  input  wire logic        result_valid_i,
  input  wire logic [31:0] operand_index_i,
  input  wire logic        shape_error_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_wdata_i,
  output int               errors_o,
  output int               outstanding_o
);
  import bcast_pkg::*;

  typedef struct packed {
    logic [31:0] flat;
    logic [31:0] index;
    logic        err;
  } lookup_t;

  logic [63:0] res_shape, opd_shape;
  logic [2:0]  res_rank, opd_rank;
  lookup_t     pending_lookups[$];

  // Mirror of the block: coordinates by division from the innermost axis,
  // weighted by the operand stride where the operand axis is not broadcast.
  function automatic lookup_t broadcast_lookup(input logic [31:0] flat);
    lookup_t     r;
    int unsigned rr, orr;
    logic [31:0] rest, acc, stride, rd, od, coord;
    r.flat = flat;
    r.index = '0;
    r.err = 1'b0;
    rr  = (res_rank > 4) ? 4 : res_rank;
    orr = (opd_rank > 4) ? 4 : opd_rank;
    if (orr == 0) return r;
    if (orr > rr) begin
      r.err = 1'b1;
      return r;
    end
    for (int k = 0; k < rr; k++) begin
      if (res_shape[16*k +: 16] == 16'd0) begin
        r.err = 1'b1;
        return r;
      end
    end
    rest = flat;
    acc = '0;
    stride = 32'd1;
    for (int k = 0; k < rr; k++) begin
      rd = {16'd0, res_shape[16*k +: 16]};
      coord = rest % rd;
      rest = rest / rd;
      if (k < orr) begin
        od = {16'd0, opd_shape[16*k +: 16]};
        if (od != 32'd1) acc = acc + coord * stride;
        stride = stride * od;
      end
    end
    r.index = acc;
    return r;
  endfunction

  assign outstanding_o = pending_lookups.size();

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t e;
    if (!rst_ni) begin
      res_shape <= ShapeReset;
      opd_shape <= ShapeReset;
      res_rank  <= '0;
      opd_rank  <= '0;
      errors_o  <= 0;
      pending_lookups.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_RESULT_SHAPE:  res_shape <= cfg_wdata_i;
          REG_OPERAND_SHAPE: opd_shape <= cfg_wdata_i;
          REG_RESULT_RANK:   res_rank  <= cfg_wdata_i[2:0];
          REG_OPERAND_RANK:  opd_rank  <= cfg_wdata_i[2:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i)
        pending_lookups = {pending_lookups, broadcast_lookup(output_index_i)};
      if (result_valid_i) begin
        if (pending_lookups.size() == 0) begin
          $display("%0t: unexpected result index %h error %b", $time,
                   operand_index_i, shape_error_i);
          errors_o <= errors_o + 1;
        end else begin
          e = pending_lookups.pop_front();
          if (e.index !== operand_index_i || e.err !== shape_error_i) begin
            $display("%0t: flat %h: expected index %h error %b, got index %h error %b",
                     $time, e.flat, e.index, e.err, operand_index_i, shape_error_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end
endmodule

[tb/broadcast_operand_index_tb.sv]
// Top of the broadcast operand index testbench: stimulus, configuration and verdict.
`timescale 1ns / 100ps
module broadcast_operand_index_tb;
  import bcast_pkg::*;

  localparam int Latency = 4 * (32 + 2);

  logic        clk, rst_n;
  logic        start, busy, result_valid, shape_error;
  logic [31:0] output_index, operand_index;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [63:0] cfg_wdata;
  int          errors, outstanding;
  bit          gaps_on;

  broadcast_operand_index dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .output_index_i(output_index), .result_valid_o(result_valid),
    .operand_index_o(operand_index), .shape_error_o(shape_error),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  broadcast_index_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy),
    .output_index_i(output_index), .result_valid_i(result_valid),
    .operand_index_i(operand_index), .shape_error_i(shape_error),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .errors_o(errors), .outstanding_o(outstanding)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #(20ns * 400000);
    $display("broadcast_operand_index regression: fail");
    $finish;
  end

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e r, input logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= r;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  // Drain the pipeline before touching the shape registers.
  task automatic set_shapes(input logic [63:0] rs, input logic [63:0] os,
                            input logic [2:0] rr, input logic [2:0] orr);
    drain();
    repeat (Latency + 8) @(posedge clk);
    write_reg(REG_RESULT_SHAPE, rs);
    write_reg(REG_OPERAND_SHAPE, os);
    write_reg(REG_RESULT_RANK, {61'd0, rr});
    write_reg(REG_OPERAND_RANK, {61'd0, orr});
    cfg_we <= 1'b0;
  endtask

  task automatic send_index(input logic [31:0] x);
    bit took;
    while (gaps_on && $urandom_range(0, 99) < 36) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    output_index <= x;
    do begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end while (!took);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [63:0] rs, os;
    logic [2:0]  rr, orr;
    logic [15:0] d;
    longint      span;
    rst_n = 1'b0;
    start = 1'b0;
    output_index = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    gaps_on = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Defaults after reset: scalar operand.
    send_index(32'h0);
    send_index(32'hFFFF_FFFF);
    send_index($urandom);
    // Full rank, mixed broadcast axes.
    set_shapes(64'h0006_0005_0004_0003, 64'h0006_0001_0004_0001, 3'd4, 3'd4);
    send_index(32'h0);
    send_index(32'hFFFF_FFFF);
    send_index(32'd359);
    send_index(32'd360);
    send_index(32'd123);
    // Operand rank above result rank.
    set_shapes(64'h0000_0000_0004_0003, 64'h0000_0002_0004_0003, 3'd2, 3'd3);
    send_index(32'd5);
    send_index(32'hFFFF_FFFF);
    // Zero in a used result axis.
    set_shapes(64'h0007_0007_0000_0003, 64'h0001_0001_0001_0003, 3'd2, 3'd1);
    send_index(32'd2);
    send_index(32'h8000_0000);
    // Rank values above the maximum saturate; widest dimensions.
    set_shapes(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 3'd5);
    send_index(32'hFFFF_FFFF);
    send_index(32'h1234_5678);
    send_index(32'h0);
    // Mismatched operand dimensions are taken as given.
    set_shapes(64'h0000_0002_0005_0003, 64'h0000_0000_0009_0007, 3'd3, 3'd2);
    send_index(32'd29);
    send_index(32'hFFFF_FFFF);
    // Scalar operand with a zero result shape.
    set_shapes(64'h0, 64'h0, 3'd6, 3'd0);
    send_index(32'hDEAD_BEEF);
    send_index(32'd0);

    for (int ph = 0; ph < 14; ph++) begin
      if (ph % 4 == 3) begin
        rs = rand64();
        os = rand64();
        rr = 3'($urandom_range(0, 7));
        orr = 3'($urandom_range(0, 7));
        span = 0;
      end else begin
        rs = rand64();
        os = rand64();
        rr = 3'($urandom_range(1, 4));
        orr = 3'($urandom_range(1, rr));
        span = 1;
        for (int k = 0; k < rr; k++) begin
          d = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 16'hFFFF))
                                            : 16'($urandom_range(1, 9));
          rs[16*k +: 16] = d;
          span = span * d;
          if (k < orr) os[16*k +: 16] = $urandom_range(0, 1) ? 16'd1 : d;
        end
      end
      set_shapes(rs, os, rr, orr);
      gaps_on = (ph != 5);
      for (int i = 0; i < 65; i++) begin
        if (ph == 2 && i == 30) drain();
        if (span > 0 && span < 64'h1_0000_0000 && $urandom_range(0, 3) != 0)
          send_index(32'($urandom_range(0, 32'(span - 1))));
        else
          send_index($urandom);
      end
    end

    drain();
    repeat (Latency + 20) @(posedge clk);
    if (errors == 0) $display("broadcast_operand_index regression: pass");
    else $display("broadcast_operand_index regression: fail");
    $finish;
  end
endmodule

[sim.f]
sv/bcast_pkg.sv
sv/broadcast_operand_index.sv
tb/broadcast_index_checker.sv
tb/broadcast_operand_index_tb.sv
